@@ hw/rtl/srsw_pkg.sv @@
package srsw_pkg;

    // Size of the circular sequence space and the widths that follow from it.
    localparam int SEQ_COUNT = 32;
    localparam int SEQ_W     = $clog2(SEQ_COUNT);
    localparam int SEQ_W1    = SEQ_W + 1;

    // Fixed field widths of the item and result transfers.
    localparam int SEQ_FIELD_W = 5;
    localparam int BLOCK_W     = 24;
    localparam int WSIZE_W     = 5;
    localparam int TIMEOUT_W   = 10;
    localparam int TIMER_W     = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 10;

    // Compare width wide enough for both a sequence field and SEQ_COUNT itself.
    localparam int CMP_W = ((SEQ_W > SEQ_FIELD_W) ? SEQ_W : SEQ_FIELD_W) + 1;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 1'd1;

    // Item opcodes.
    localparam logic OP_ACK  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic                   opcode;
        logic [SEQ_FIELD_W-1:0] ack_seq;
    } item_t;

    typedef struct packed {
        logic [SEQ_FIELD_W-1:0] packet_seq;
        logic [BLOCK_W-1:0]     payload_block;
        logic                   is_resend;
    } result_t;

    // Per-sequence state held in one cell of the ring.
    typedef struct packed {
        logic [TIMER_W-1:0] timer;
        logic               acked;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_TICK,
        ST_ALIGN
    } state_t;

    function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        logic [SEQ_W1-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SEQ_W1'(SEQ_COUNT))
        begin
            s = s - SEQ_W1'(SEQ_COUNT);
        end
        return s[SEQ_W-1:0];
    endfunction

    function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] from,
                                                  input logic [SEQ_W-1:0] to);
        logic [SEQ_W1-1:0] d;
        d = {1'b0, to} + SEQ_W1'(SEQ_COUNT) - {1'b0, from};
        if (d >= SEQ_W1'(SEQ_COUNT))
        begin
            d = d - SEQ_W1'(SEQ_COUNT);
        end
        return d[SEQ_W-1:0];
    endfunction

endpackage

@@ hw/rtl/srsw_cell.sv @@
// One slot of the rotating ring. When the ring turns, the cell takes the
// slot held by its neighbor.
module srsw_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  srsw_pkg::slot_t din,
    output srsw_pkg::slot_t q
);

    srsw_pkg::slot_t slot_reg;
    srsw_pkg::slot_t slot_next;

    always_comb
    begin
        slot_next = shift ? din : slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign q = slot_reg;

endmodule

@@ hw/rtl/selective_repeat_sender_window_top.sv @@
// Tick: accepted at start; any result strobe follows once the ring has turned once.
// Ack: busy while the ring turns once and then on as far as the base slides.
// A new item is accepted only while busy is low, so never before the last one is done.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset is asynchronous and active low and clears all slots and control counters at once.
// Window size resets to 7 and the timeout to 20 ticks.
//
// The per-sequence state (timer and acked bit) lives in a ring of SEQ_COUNT
// identical cells. The cell at the head of the ring always holds the sequence
// named by head_reg, and while idle the head sits at the window base. An item
// turns the ring once: every cycle one slot passes the head, where it is aged
// or marked, and goes back in at the tail. Slots therefore pass in order of
// their offset from the window base, which makes "oldest expired slot" and the
// base slide simple sequential decisions. After an ack slides the base, the
// ring turns on until the head is back at the new base.
//
// A slot outside the outstanding range always holds zero: the slide clears
// each slot it passes, so a new packet needs no write into its cell.
module selective_repeat_sender_window_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  srsw_pkg::item_t                      item,
    input  logic                                 cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [srsw_pkg::CFG_W-1:0]           cfg_data,
    output logic                                 result_valid,
    output srsw_pkg::result_t                    result
);

    localparam int N     = srsw_pkg::SEQ_COUNT;
    localparam int SW    = srsw_pkg::SEQ_W;
    localparam int CW    = srsw_pkg::CMP_W;
    localparam int BW    = srsw_pkg::BLOCK_W;
    localparam int TW    = srsw_pkg::TIMER_W;

    // Control state.
    srsw_pkg::state_t        state_reg, state_next;
    logic [SW-1:0]           k_reg, k_next;            // offset of the head slot
    logic [SW-1:0]           head_reg, head_next;      // sequence at the head cell
    logic [SW-1:0]           base_reg, base_next;
    logic [SW-1:0]           nseq_reg, nseq_next;      // next unsent sequence
    logic [BW-1:0]           deliv_reg, deliv_next;
    logic [SW-1:0]           cnt_reg, cnt_next;        // outstanding count at accept
    logic [SW-1:0]           ack_s_reg, ack_s_next;
    logic                    ack_ok_reg, ack_ok_next;
    logic                    slide_reg, slide_next;
    logic [SW-1:0]           slcnt_reg, slcnt_next;
    logic                    found_reg, found_next;
    logic [SW-1:0]           foff_reg, foff_next;
    logic [SW-1:0]           fseq_reg, fseq_next;
    logic                    rv_reg, rv_next;
    srsw_pkg::result_t       res_reg, res_next;
    logic [srsw_pkg::WSIZE_W-1:0]   ws_reg;
    logic [srsw_pkg::TIMEOUT_W-1:0] to_reg;

    // Ring of cells.
    srsw_pkg::slot_t         cell_q [N];
    srsw_pkg::slot_t         cell_d [N];
    srsw_pkg::slot_t         head_new;
    logic                    shift;

    for (genvar i = 0; i < N; i++)
    begin : g_ring
        if (i == N - 1)
        begin : g_tail
            assign cell_d[i] = head_new;
        end
        else
        begin : g_mid
            assign cell_d[i] = cell_q[i+1];
        end

        srsw_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .din   (cell_d[i]),
            .q     (cell_q[i])
        );
    end

    // Values used around the controller.
    logic [SW-1:0] cnt_now;
    logic [CW-1:0] ack_ext;
    logic [SW-1:0] ack_s_in;
    logic          in_win;
    logic          last;
    logic          mark;
    logic          acked_eff;
    logic [TW-1:0] t_inc;
    logic          expired;
    logic [CW-1:0] eff_win;
    logic          room;

    always_comb
    begin
        cnt_now  = srsw_pkg::seq_dist(base_reg, nseq_reg);
        ack_ext  = CW'(item.ack_seq);
        ack_s_in = SW'(item.ack_seq);
        in_win   = k_reg < cnt_reg;
        last     = k_reg == SW'(N - 1);
        mark     = ack_ok_reg && (head_reg == ack_s_reg);
        acked_eff = cell_q[0].acked | mark;
        t_inc    = (cell_q[0].timer == srsw_pkg::TIMER_MAX) ? cell_q[0].timer
                                                             : cell_q[0].timer + TW'(1);
        expired  = t_inc > TW'(to_reg);
        eff_win  = (CW'(ws_reg) > CW'(N - 1)) ? CW'(N - 1) : CW'(ws_reg);
        room     = CW'(cnt_reg) < eff_win;
    end

    // Next state, head processing and outputs.
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        head_next   = head_reg;
        base_next   = base_reg;
        nseq_next   = nseq_reg;
        deliv_next  = deliv_reg;
        cnt_next    = cnt_reg;
        ack_s_next  = ack_s_reg;
        ack_ok_next = ack_ok_reg;
        slide_next  = slide_reg;
        slcnt_next  = slcnt_reg;
        found_next  = found_reg;
        foff_next   = foff_reg;
        fseq_next   = fseq_reg;
        rv_next     = 1'b0;
        res_next    = res_reg;
        head_new    = cell_q[0];
        shift       = 1'b0;

        case (state_reg)
            srsw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    k_next      = '0;
                    cnt_next    = cnt_now;
                    ack_s_next  = ack_s_in;
                    ack_ok_next = (ack_ext < CW'(N)) &&
                                  (srsw_pkg::seq_dist(base_reg, ack_s_in) < cnt_now);
                    slide_next  = ack_ok_next && (ack_s_in == base_reg);
                    slcnt_next  = '0;
                    found_next  = 1'b0;
                    state_next  = (item.opcode == srsw_pkg::OP_TICK) ? srsw_pkg::ST_TICK
                                                                     : srsw_pkg::ST_ACK;
                end
            end

            srsw_pkg::ST_ACK:
            begin
                shift     = 1'b1;
                head_next = srsw_pkg::seq_add(head_reg, SW'(1));
                k_next    = k_reg + SW'(1);
                if (slide_reg && in_win && acked_eff)
                begin
                    // The base passes this slot: hand it back clean.
                    head_new   = '0;
                    slcnt_next = slcnt_reg + SW'(1);
                end
                else
                begin
                    slide_next     = 1'b0;
                    head_new.acked = acked_eff;
                end
                if (last)
                begin
                    base_next  = srsw_pkg::seq_add(base_reg, slcnt_next);
                    deliv_next = deliv_reg + BW'(slcnt_next);
                    state_next = (slcnt_next != '0) ? srsw_pkg::ST_ALIGN
                                                    : srsw_pkg::ST_IDLE;
                end
            end

            srsw_pkg::ST_TICK:
            begin
                shift     = 1'b1;
                head_next = srsw_pkg::seq_add(head_reg, SW'(1));
                k_next    = k_reg + SW'(1);
                if (in_win && !cell_q[0].acked)
                begin
                    if (expired && !found_reg)
                    begin
                        // Oldest expired slot: it is resent, so its timer restarts.
                        found_next     = 1'b1;
                        foff_next      = k_reg;
                        fseq_next      = head_reg;
                        head_new.timer = '0;
                    end
                    else
                    begin
                        head_new.timer = t_inc;
                    end
                end
                if (last)
                begin
                    state_next = srsw_pkg::ST_IDLE;
                    if (found_next)
                    begin
                        rv_next                = 1'b1;
                        res_next.packet_seq    = srsw_pkg::SEQ_FIELD_W'(fseq_next);
                        res_next.payload_block = deliv_reg + BW'(foff_next);
                        res_next.is_resend     = 1'b1;
                    end
                    else if (room)
                    begin
                        rv_next                = 1'b1;
                        res_next.packet_seq    = srsw_pkg::SEQ_FIELD_W'(nseq_reg);
                        res_next.payload_block = deliv_reg + BW'(cnt_reg);
                        res_next.is_resend     = 1'b0;
                        nseq_next              = srsw_pkg::seq_add(nseq_reg, SW'(1));
                    end
                end
            end

            srsw_pkg::ST_ALIGN:
            begin
                // Turn the ring, slots unchanged, until the head is the new base.
                shift     = 1'b1;
                head_next = srsw_pkg::seq_add(head_reg, SW'(1));
                if (head_next == base_reg)
                begin
                    state_next = srsw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = srsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= srsw_pkg::ST_IDLE;
            k_reg      <= '0;
            head_reg   <= '0;
            base_reg   <= '0;
            nseq_reg   <= '0;
            deliv_reg  <= '0;
            ack_ok_reg <= 1'b0;
            slide_reg  <= 1'b0;
            slcnt_reg  <= '0;
            found_reg  <= 1'b0;
            rv_reg     <= 1'b0;
            ws_reg     <= srsw_pkg::WSIZE_W'(7);
            to_reg     <= srsw_pkg::TIMEOUT_W'(20);
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            head_reg   <= head_next;
            base_reg   <= base_next;
            nseq_reg   <= nseq_next;
            deliv_reg  <= deliv_next;
            ack_ok_reg <= ack_ok_next;
            slide_reg  <= slide_next;
            slcnt_reg  <= slcnt_next;
            found_reg  <= found_next;
            rv_reg     <= rv_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    srsw_pkg::REG_WINDOW_SIZE: ws_reg <= cfg_data[srsw_pkg::WSIZE_W-1:0];
                    srsw_pkg::REG_TIMEOUT:     to_reg <= cfg_data[srsw_pkg::TIMEOUT_W-1:0];
                    default:                   ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        ack_s_reg <= ack_s_next;
        foff_reg  <= foff_next;
        fseq_reg  <= fseq_next;
        res_reg   <= res_next;
    end

    assign busy         = state_reg != srsw_pkg::ST_IDLE;
    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

@@ hw/rtl/srsw_checker.sv @@
// Port-level checks on the sender window.
module srsw_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input srsw_pkg::item_t   item,
    input logic              result_valid
);

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted item");

    // A result transfer is shown only once the item's work is done.
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // At most one result per item: no two strobes in a row.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    // An ack item never causes a result right after acceptance.
    a_ack_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.opcode == srsw_pkg::OP_ACK) |=> !result_valid)
        else $error("result after an ack item");

endmodule

bind selective_repeat_sender_window_top srsw_checker u_srsw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid)
);

@@ tb/selective_repeat_sender_window_top_tb.sv @@
module selective_repeat_sender_window_top_tb;

    import srsw_pkg::*;

    // Longest time the block may take with one item: an ack turns the ring once and then
    // again as far as the base slides. The pause before a register write or the final
    // verdict covers this, since an ack leaves no result behind to wait for.
    localparam int ITEM_LATENCY = 2 * SEQ_COUNT + 8;
    localparam int SETTLE_LIMIT = 8 * SEQ_COUNT + 200;
    localparam int CYCLE_LIMIT  = 600000;

    // One row of the directed table. Where typed is set, the row carries the packet
    // that must come out (or, with has_pkt clear, that no packet may come out);
    // otherwise the window predictor decides.
    typedef struct packed {
        logic                   op;
        logic [SEQ_FIELD_W-1:0] seq;
        bit                     typed;
        bit                     has_pkt;
        logic [SEQ_FIELD_W-1:0] pkt_seq;
        logic [BLOCK_W-1:0]     pkt_block;
        bit                     pkt_resend;
    } directed_row_t;

    // The directed table runs under the reset settings: window 7, timeout 20.
    localparam directed_row_t DIRECTED [25] = '{
        // An ack with nothing outstanding must be ignored.
        '{OP_ACK,  5'd0,  1'b1, 1'b0, 5'd0,  24'd0, 1'b0},
        // The first two ticks open sequences 0 and 1 as new packets.
        '{OP_TICK, 5'd0,  1'b1, 1'b1, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd17, 1'b1, 1'b1, 5'd1,  24'd1, 1'b0},
        // Sequence 5 was never sent, so its ack is outside the window.
        '{OP_ACK,  5'd5,  1'b1, 1'b0, 5'd0,  24'd0, 1'b0},
        // Ack above the base, then the same ack again.
        '{OP_ACK,  5'd1,  1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_ACK,  5'd1,  1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd0,  1'b1, 1'b1, 5'd2,  24'd2, 1'b0},
        // Acking the base slides it over 0 and 1; two blocks are delivered.
        '{OP_ACK,  5'd0,  1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd0,  1'b1, 1'b1, 5'd3,  24'd3, 1'b0},
        '{OP_ACK,  5'd31, 1'b1, 1'b0, 5'd0,  24'd0, 1'b0},
        // The slide over 2 and 3 stops at the next unsent sequence: the window empties.
        '{OP_ACK,  5'd3,  1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_ACK,  5'd2,  1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd0,  1'b1, 1'b1, 5'd4,  24'd4, 1'b0},
        // Fill the window up to seven outstanding sequences.
        '{OP_TICK, 5'd31, 1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd10, 1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd21, 1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd0,  1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd7,  1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd24, 1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        // Window full and nothing expired: the tick sends nothing.
        '{OP_TICK, 5'd31, 1'b1, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_ACK,  5'd30, 1'b1, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_ACK,  5'd7,  1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_ACK,  5'd4,  1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd21, 1'b0, 1'b0, 5'd0,  24'd0, 1'b0},
        '{OP_TICK, 5'd31, 1'b0, 1'b0, 5'd0,  24'd0, 1'b0}
    };

    // Random phases: register settings and the number of items that do something.
    // The settings include both extremes of each register, a window of zero that
    // only lets retransmissions out, and a zero timeout that expires every slot.
    typedef struct packed {
        logic [WSIZE_W-1:0]   win;
        logic [TIMEOUT_W-1:0] tmo;
        logic [15:0]          items;
    } phase_t;

    localparam phase_t PHASES [7] = '{
        '{5'd31, 10'd0,    16'd120},
        '{5'd1,  10'd1023, 16'd60},
        '{5'd0,  10'd4,    16'd40},
        '{5'd5,  10'd2,    16'd150},
        '{5'd16, 10'd9,    16'd150},
        '{5'd31, 10'd1023, 16'd100},
        '{5'd3,  10'd1,    16'd80}
    };
    // The phase that runs with no idling at all on the command side.
    localparam int STEADY_PHASE = 3;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic    result_valid;
    result_t result;

    selective_repeat_sender_window_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // Our own copy of the sender window, updated whenever a transfer is accepted.
    logic [TIMER_W-1:0]   slot_age [SEQ_COUNT];
    bit                   slot_ack [SEQ_COUNT];
    int                   win_base;
    int                   win_next;
    logic [BLOCK_W-1:0]   delivered;
    logic [WSIZE_W-1:0]   cfg_window;
    logic [TIMEOUT_W-1:0] cfg_timeout;

    // Packets the block still owes us, oldest first.
    result_t pending_packets [$];

    int  err_count;
    int  cycle_count;
    bit  idle_en;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Distance from one sequence to another, going forward around the ring.
    function automatic int ring_gap(input int from, input int to);
        return (to + SEQ_COUNT - from) % SEQ_COUNT;
    endfunction

    // Only the first ten failures are described; the rest are just counted.
    function automatic void note_failure(input string msg);
        err_count++;
        if (err_count <= 10)
        begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    // Applies one accepted item to the window copy. Returns 0 for an ack that the
    // block must ignore, 1 otherwise; emits and pkt give the packet a tick sends.
    function automatic bit window_step(input item_t it, output bit emits,
                                       output result_t pkt);
        int cnt;
        int s;
        int off;
        int lim;
        bit found;

        cnt   = ring_gap(win_base, win_next);
        emits = 1'b0;
        pkt   = '0;

        if (it.opcode == OP_ACK)
        begin
            s = int'(it.ack_seq);
            if (s >= SEQ_COUNT || ring_gap(win_base, s) >= cnt)
            begin
                return 1'b0;
            end
            slot_ack[s] = 1'b1;
            // Only an ack of the base moves the window; it then sweeps over every
            // acknowledged slot but never past the next unsent sequence.
            if (s == win_base)
            begin
                while (win_base != win_next && slot_ack[win_base])
                begin
                    slot_ack[win_base] = 1'b0;
                    win_base  = (win_base + 1) % SEQ_COUNT;
                    delivered = delivered + 1'b1;
                end
            end
            return 1'b1;
        end

        // Tick: age every unacknowledged outstanding slot and remember the first,
        // counted from the base, whose age has passed the timeout.
        found = 1'b0;
        off   = 0;
        for (int k = 0; k < cnt; k++)
        begin
            s = (win_base + k) % SEQ_COUNT;
            if (!slot_ack[s])
            begin
                if (slot_age[s] < TIMER_MAX)
                begin
                    slot_age[s] = slot_age[s] + 1'b1;
                end
                if (!found && slot_age[s] > cfg_timeout)
                begin
                    found = 1'b1;
                    off   = k;
                end
            end
        end

        if (found)
        begin
            s = (win_base + off) % SEQ_COUNT;
            slot_age[s]       = '0;
            emits             = 1'b1;
            pkt.packet_seq    = SEQ_FIELD_W'(s);
            pkt.payload_block = delivered + BLOCK_W'(off);
            pkt.is_resend     = 1'b1;
            return 1'b1;
        end

        // A window setting at or beyond the ring size behaves as one less than it.
        lim = (int'(cfg_window) > SEQ_COUNT - 1) ? SEQ_COUNT - 1 : int'(cfg_window);
        if (cnt < lim)
        begin
            s = win_next;
            slot_age[s]       = '0;
            slot_ack[s]       = 1'b0;
            win_next          = (win_next + 1) % SEQ_COUNT;
            emits             = 1'b1;
            pkt.packet_seq    = SEQ_FIELD_W'(s);
            pkt.payload_block = delivered + BLOCK_W'(cnt);
            pkt.is_resend     = 1'b0;
        end
        return 1'b1;
    endfunction

    // Random items are mostly ticks and acks of sequences that are really in flight,
    // with a strong lean toward the base so that the window keeps sliding. About one
    // in ten is an ack of an arbitrary sequence, which is usually ignored.
    function automatic item_t pick_item();
        item_t it;
        int    cnt;
        int    r;

        cnt        = ring_gap(win_base, win_next);
        r          = $urandom_range(0, 99);
        it.ack_seq = SEQ_FIELD_W'($urandom);
        if (r < 50)
        begin
            it.opcode = OP_TICK;
        end
        else
        begin
            it.opcode = OP_ACK;
            if (r < 90 && cnt > 0)
            begin
                if ($urandom_range(0, 99) < 45)
                begin
                    it.ack_seq = SEQ_FIELD_W'(win_base);
                end
                else
                begin
                    it.ack_seq = SEQ_FIELD_W'((win_base + $urandom_range(0, cnt - 1))
                                              % SEQ_COUNT);
                end
            end
        end
        return it;
    endfunction

    // Presents one item and waits for its transfer. Inputs change on the falling
    // edge; the transfer happens at the first rising edge that sees busy low. Start
    // stays high afterwards unless an idle gap follows, so back-to-back items never
    // see start lowered and raised in the same time step.
    task automatic send_transfer(input item_t it, input bit use_typed, input bit typed_has,
                                 input result_t typed_pkt, output bit counted);
        bit      emits;
        result_t pkt;

        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        counted = window_step(it, emits, pkt);
        if (use_typed)
        begin
            if (typed_has)
            begin
                pending_packets.push_back(typed_pkt);
            end
        end
        else if (emits)
        begin
            pending_packets.push_back(pkt);
        end

        // Idle gaps of random length land on every phase of the ring walk.
        if (idle_en && $urandom_range(0, 99) < 31)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 70)) @(negedge clk);
        end
    endtask

    // Stops issuing items and waits until the block has delivered all it owes and
    // has had time to finish an ack, which leaves no packet to wait for.
    task automatic settle();
        int waited;

        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (pending_packets.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (ITEM_LATENCY) @(posedge clk);
        if (pending_packets.size() != 0)
        begin
            note_failure($sformatf("%0d expected packets never came out",
                                   pending_packets.size()));
            pending_packets.delete();
        end
    endtask

    // Register writes happen only while the block is idle, so the window copy can
    // take the new value at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        if (idx == REG_WINDOW_SIZE)
        begin
            cfg_window = data[WSIZE_W-1:0];
        end
        else
        begin
            cfg_timeout = data[TIMEOUT_W-1:0];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Every packet strobe is compared with the oldest packet still owed.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_packets.size() == 0)
            begin
                note_failure($sformatf("packet with none owed: seq %0d block %0d resend %0b",
                                       result.packet_seq, result.payload_block,
                                       result.is_resend));
            end
            else
            begin
                want = pending_packets.pop_front();
                if (want.packet_seq !== result.packet_seq ||
                    want.payload_block !== result.payload_block ||
                    want.is_resend !== result.is_resend)
                begin
                    note_failure($sformatf({"packet mismatch: expected seq %0d block %0d ",
                                            "resend %0b, got seq %0d block %0d resend %0b"},
                                           want.packet_seq, want.payload_block,
                                           want.is_resend, result.packet_seq,
                                           result.payload_block, result.is_resend));
                end
            end
        end
    end

    // A hang anywhere ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("selective_repeat_sender_window_top test failed");
        $finish;
    end

    initial
    begin
        item_t   it;
        result_t typed_pkt;
        bit      counted;
        int      done;

        start       = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        err_count   = 0;
        cycle_count = 0;
        idle_en     = 1'b1;

        // The window copy starts where the block does after reset.
        for (int k = 0; k < SEQ_COUNT; k++)
        begin
            slot_age[k] = '0;
            slot_ack[k] = 1'b0;
        end
        win_base    = 0;
        win_next    = 0;
        delivered   = '0;
        cfg_window  = 5'd7;
        cfg_timeout = 10'd20;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset register values.
        foreach (DIRECTED[i])
        begin
            it.opcode                 = DIRECTED[i].op;
            it.ack_seq                = DIRECTED[i].seq;
            typed_pkt.packet_seq      = DIRECTED[i].pkt_seq;
            typed_pkt.payload_block   = DIRECTED[i].pkt_block;
            typed_pkt.is_resend       = DIRECTED[i].pkt_resend;
            send_transfer(it, DIRECTED[i].typed, DIRECTED[i].has_pkt, typed_pkt, counted);
        end

        // Random phases. The window state carries over from one phase to the next,
        // so a smaller window or a longer timeout also meets slots already in flight.
        foreach (PHASES[p])
        begin
            settle();
            write_reg(REG_WINDOW_SIZE, CFG_W'(PHASES[p].win));
            write_reg(REG_TIMEOUT, CFG_W'(PHASES[p].tmo));
            idle_en = (p != STEADY_PHASE);
            done    = 0;
            while (done < int'(PHASES[p].items))
            begin
                send_transfer(pick_item(), 1'b0, 1'b0, '0, counted);
                if (counted)
                begin
                    done++;
                end
            end
        end

        settle();
        if (err_count == 0)
        begin
            $display("selective_repeat_sender_window_top test passed");
        end
        else
        begin
            $display("selective_repeat_sender_window_top test failed");
        end
        $finish;
    end

endmodule

@@ selective_repeat_sender_window_top.f @@
hw/rtl/srsw_pkg.sv
hw/rtl/srsw_cell.sv
hw/rtl/selective_repeat_sender_window_top.sv
hw/rtl/srsw_checker.sv
tb/selective_repeat_sender_window_top_tb.sv
